### design/sifp_pkg.sv
package sifp_pkg;

  // field set address order
  localparam logic [7:0] ORDER_SBA = 8'h11;
  // data byte index saturates here
  localparam logic [11:0] OFFSET_MAX = 12'hFFF;
  // bytes after a bad order needed to report it
  localparam logic [1:0] BAD_NEEDED = 2'd3;

  // result queue sizing
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_ATTN    = 3'd0,
    PH_CUR_HI  = 3'd1,
    PH_CUR_LO  = 3'd2,
    PH_ORDER   = 3'd3,
    PH_ADDR_HI = 3'd4,
    PH_ADDR_LO = 3'd5,
    PH_DATA    = 3'd6,
    PH_BAD     = 3'd7
  } sifp_phase_t;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_HEADER = 3'd1,
    KIND_END_OK = 3'd2,
    KIND_SHORT  = 3'd3,
    KIND_BAD    = 3'd4
  } sifp_kind_t;

  typedef struct packed {
    sifp_phase_t  phase;
    logic [7:0]   attention;
    logic [7:0]   high_byte;
    logic [11:0]  cursor;
    logic [11:0]  field_start;
    logic [11:0]  offset;
    logic [1:0]   bad_count;
  } sifp_state_t;

  typedef struct packed {
    sifp_kind_t   kind;
    logic [7:0]   attention;
    logic [11:0]  cursor;
    logic [11:0]  field;
    logic [11:0]  offset;
    logic [7:0]   data;
    logic         final_flag;
  } sifp_result_t;

  localparam sifp_state_t STATE_RESET = '{
    phase: PH_ATTN, attention: 8'd0, high_byte: 8'd0, cursor: 12'd0,
    field_start: 12'd0, offset: 12'd0, bad_count: 2'd0
  };

  localparam sifp_result_t RESULT_ZERO = '{
    kind: KIND_DATA, attention: 8'd0, cursor: 12'd0, field: 12'd0,
    offset: 12'd0, data: 8'd0, final_flag: 1'b0
  };

  // buffer address: low six bits of each byte
  function automatic logic [11:0] decode_addr(input logic [7:0] hi, input logic [7:0] lo);
    return {hi[5:0], lo[5:0]};
  endfunction

endpackage

### design/sifp_step.sv
module sifp_step (
  input  sifp_pkg::sifp_state_t  state,
  input  logic [7:0]             stream_byte,
  input  logic                   message_end,
  output sifp_pkg::sifp_state_t  state_next,
  output sifp_pkg::sifp_result_t res0,
  output sifp_pkg::sifp_result_t res1,
  output logic [1:0]             res_count
);

  sifp_pkg::sifp_state_t  nx;
  sifp_pkg::sifp_result_t primary;
  sifp_pkg::sifp_result_t end_res;
  sifp_pkg::sifp_result_t short_res;
  sifp_pkg::sifp_kind_t   end_kind;
  logic                   prim_valid;
  logic                   is_short;
  logic [11:0]            addr;
  logic [1:0]             bad_inc;

  assign addr = sifp_pkg::decode_addr(state.high_byte, stream_byte);

  // per-phase byte handling
  always_comb begin
    nx = state;
    primary = sifp_pkg::RESULT_ZERO;
    prim_valid = 1'b0;
    end_kind = sifp_pkg::KIND_END_OK;
    is_short = 1'b0;
    bad_inc = state.bad_count;
    case (state.phase)
      sifp_pkg::PH_ATTN: begin
        nx.attention = stream_byte;
        nx.phase = sifp_pkg::PH_CUR_HI;
        is_short = message_end;
      end
      sifp_pkg::PH_CUR_HI: begin
        nx.high_byte = stream_byte;
        nx.phase = sifp_pkg::PH_CUR_LO;
        is_short = message_end;
      end
      sifp_pkg::PH_CUR_LO: begin
        nx.cursor = addr;
        nx.phase = sifp_pkg::PH_ORDER;
        primary.kind = sifp_pkg::KIND_HEADER;
        primary.attention = state.attention;
        primary.cursor = addr;
        prim_valid = 1'b1;
      end
      sifp_pkg::PH_ORDER: begin
        if (stream_byte == sifp_pkg::ORDER_SBA) begin
          nx.phase = sifp_pkg::PH_ADDR_HI;
        end else begin
          nx.phase = sifp_pkg::PH_BAD;
          nx.bad_count = 2'd0;
        end
      end
      sifp_pkg::PH_ADDR_HI: begin
        nx.high_byte = stream_byte;
        nx.phase = sifp_pkg::PH_ADDR_LO;
      end
      sifp_pkg::PH_ADDR_LO: begin
        nx.field_start = addr;
        nx.offset = 12'd0;
        nx.phase = sifp_pkg::PH_DATA;
      end
      sifp_pkg::PH_DATA: begin
        if (stream_byte == sifp_pkg::ORDER_SBA) begin
          nx.phase = sifp_pkg::PH_ADDR_HI;
        end else begin
          primary.kind = sifp_pkg::KIND_DATA;
          primary.attention = state.attention;
          primary.cursor = state.cursor;
          primary.field = state.field_start;
          primary.offset = state.offset;
          primary.data = stream_byte;
          prim_valid = 1'b1;
          if (state.offset < sifp_pkg::OFFSET_MAX) begin
            nx.offset = state.offset + 12'd1;
          end
        end
      end
      sifp_pkg::PH_BAD: begin
        if (state.bad_count < sifp_pkg::BAD_NEEDED) begin
          bad_inc = state.bad_count + 2'd1;
        end
        nx.bad_count = bad_inc;
        if (bad_inc >= sifp_pkg::BAD_NEEDED) begin
          end_kind = sifp_pkg::KIND_BAD;
        end
      end
      default: begin
        nx = state;
      end
    endcase
  end

  // end-of-message result uses the updated header and field values
  always_comb begin
    end_res = sifp_pkg::RESULT_ZERO;
    end_res.kind = end_kind;
    end_res.attention = nx.attention;
    end_res.cursor = nx.cursor;
    end_res.field = nx.field_start;
    end_res.final_flag = 1'b1;
    short_res = sifp_pkg::RESULT_ZERO;
    short_res.kind = sifp_pkg::KIND_SHORT;
    short_res.final_flag = 1'b1;
  end

  // order the results and return to idle at message end
  always_comb begin
    res0 = sifp_pkg::RESULT_ZERO;
    res1 = sifp_pkg::RESULT_ZERO;
    res_count = 2'd0;
    if (is_short) begin
      res0 = short_res;
      res_count = 2'd1;
    end else if (prim_valid) begin
      res0 = primary;
      res1 = end_res;
      res_count = message_end ? 2'd2 : 2'd1;
    end else begin
      res0 = end_res;
      res_count = message_end ? 2'd1 : 2'd0;
    end
    state_next = message_end ? sifp_pkg::STATE_RESET : nx;
  end

endmodule

### design/sifp_result_queue.sv
module sifp_result_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             push_count,
  input  sifp_pkg::sifp_result_t push0,
  input  sifp_pkg::sifp_result_t push1,
  input  logic                   pop,
  output sifp_pkg::sifp_result_t head,
  output logic                   not_empty,
  output logic                   has_room
);

  sifp_pkg::sifp_result_t        entries [sifp_pkg::QUEUE_DEPTH];
  logic [sifp_pkg::PTR_W-1:0]    wr_ptr;
  logic [sifp_pkg::PTR_W-1:0]    rd_ptr;
  logic [sifp_pkg::CNT_W-1:0]    count;
  logic [sifp_pkg::CNT_W-1:0]    count_next;
  logic [sifp_pkg::PTR_W-1:0]    wr_ptr_1;

  assign wr_ptr_1 = wr_ptr + sifp_pkg::PTR_W'(1);
  assign count_next = count + sifp_pkg::CNT_W'(push_count)
                      - sifp_pkg::CNT_W'(pop);
  assign not_empty = (count != '0);
  // room for the two results one byte can cause
  assign has_room = (count <= sifp_pkg::CNT_W'(sifp_pkg::QUEUE_DEPTH - 2));
  assign head = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + sifp_pkg::PTR_W'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + sifp_pkg::PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr_1] <= push1;
    end
  end

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    (push_count != 2'd0) |-> has_room)
    else $error("result queue overflow");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("result queue underflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sifp_pkg::CNT_W'(sifp_pkg::QUEUE_DEPTH))
    else $error("result queue count out of range");

endmodule

### design/screen_inbound_field_parser_top.sv
// Inbound read-modified message parser. Takes one message byte per transaction
// and gives the header, one result per field data byte, and a closing status
// result marked final. A byte enters an input register, is parsed combinationally
// against the parse state, and its zero, one or two results go into a
// four-entry result queue that drives the output channel. One byte is taken
// every cycle as long as the queue has room for two results; a byte that ends
// the message after a data byte or the cursor address gives two results and so
// takes two transactions on the output side.
module screen_inbound_field_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        stream_valid,
  output logic        stream_stall,
  input  logic [7:0]  stream_byte,
  input  logic        message_end,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  result_kind,
  output logic [7:0]  attention_code,
  output logic [11:0] cursor_position,
  output logic [11:0] field_position,
  output logic [11:0] byte_offset,
  output logic [7:0]  data_value,
  output logic        final_result
);

  sifp_pkg::sifp_state_t  state;
  sifp_pkg::sifp_state_t  state_next;
  sifp_pkg::sifp_result_t res0;
  sifp_pkg::sifp_result_t res1;
  sifp_pkg::sifp_result_t head;
  logic [1:0]             res_count;
  logic                   in_full;
  logic [7:0]             in_byte;
  logic                   in_end;
  logic                   advance;
  logic                   has_room;
  logic                   not_empty;
  logic                   pop;

  // input register handshake
  assign advance = in_full & has_room;
  assign stream_stall = in_full & ~has_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (stream_valid && !stream_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream_valid && !stream_stall) begin
      in_byte <= stream_byte;
      in_end <= message_end;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sifp_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  sifp_step u_step (
    .state       (state),
    .stream_byte (in_byte),
    .message_end (in_end),
    .state_next  (state_next),
    .res0        (res0),
    .res1        (res1),
    .res_count   (res_count)
  );

  // result queue
  assign pop = not_empty & ~result_stall;

  sifp_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (advance ? res_count : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .has_room   (has_room)
  );

  // output ports
  assign result_valid = not_empty;
  assign result_kind = head.kind;
  assign attention_code = head.attention;
  assign cursor_position = head.cursor;
  assign field_position = head.field;
  assign byte_offset = head.offset;
  assign data_value = head.data;
  assign final_result = head.final_flag;

  a_end_resets_phase: assert property (@(posedge clk) disable iff (rst)
    (advance && in_end) |=> (state.phase == sifp_pkg::PH_ATTN))
    else $error("parse phase not idle after message end");

  a_short_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind == sifp_pkg::KIND_SHORT) |->
      (attention_code == 8'd0 && cursor_position == 12'd0 && final_result))
    else $error("short message result carries values");

endmodule

### tb/sv/screen_inbound_field_parser_top_tb.sv
`timescale 1ns / 100ps

module screen_inbound_field_parser_top_tb;
  import sifp_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 680;

  logic        clk;
  logic        rst = 1'b1;
  logic        stream_valid = 1'b0;
  logic        stream_stall;
  logic [7:0]  stream_byte = 8'd0;
  logic        message_end = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b1;
  logic [2:0]  result_kind;
  logic [7:0]  attention_code;
  logic [11:0] cursor_position;
  logic [11:0] field_position;
  logic [11:0] byte_offset;
  logic [7:0]  data_value;
  logic        final_result;

  // parser state as the scoreboard tracks it
  sifp_phase_t exp_phase = PH_ATTN;
  logic [7:0]  exp_attention = 8'd0;
  logic [7:0]  exp_high_byte = 8'd0;
  logic [11:0] exp_cursor = 12'd0;
  logic [11:0] exp_field = 12'd0;
  logic [11:0] exp_offset = 12'd0;
  logic [1:0]  exp_bad_count = 2'd0;

  sifp_result_t pending_results[$];
  logic [7:0]   msg_bytes[$];
  sifp_result_t head_result;

  bit quiet_gaps = 1'b0;
  bit hold_request = 1'b0;
  int mismatches = 0;
  int idle_cycles = 0;
  int bytes_sent = 0;
  int messages_sent = 0;
  int results_checked = 0;
  int data_results = 0;
  int bad_order_results = 0;
  int short_results = 0;

  screen_inbound_field_parser_top uut (
    .clk             (clk),
    .rst             (rst),
    .stream_valid    (stream_valid),
    .stream_stall    (stream_stall),
    .stream_byte     (stream_byte),
    .message_end     (message_end),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result_kind     (result_kind),
    .attention_code  (attention_code),
    .cursor_position (cursor_position),
    .field_position  (field_position),
    .byte_offset     (byte_offset),
    .data_value      (data_value),
    .final_result    (final_result)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // append one expected result
  function automatic void queue_result(sifp_kind_t kind, logic [7:0] attn, logic [11:0] cur,
                                       logic [11:0] fld, logic [11:0] off, logic [7:0] data,
                                       logic fin);
    sifp_result_t r;
    r.kind       = kind;
    r.attention  = attn;
    r.cursor     = cur;
    r.field      = fld;
    r.offset     = off;
    r.data       = data;
    r.final_flag = fin;
    pending_results.push_back(r);
  endfunction

  // track the parser through one accepted byte and queue what it must produce
  function automatic void parse_byte_model(logic [7:0] b, logic last);
    sifp_phase_t entry_phase;
    sifp_kind_t  close_kind;
    entry_phase = exp_phase;
    close_kind  = KIND_END_OK;
    case (exp_phase)
      PH_ATTN: begin
        exp_attention = b;
        exp_phase = PH_CUR_HI;
      end
      PH_CUR_HI: begin
        exp_high_byte = b;
        exp_phase = PH_CUR_LO;
      end
      PH_CUR_LO: begin
        exp_cursor = {exp_high_byte[5:0], b[5:0]};
        queue_result(KIND_HEADER, exp_attention, exp_cursor, 12'd0, 12'd0, 8'd0, 1'b0);
        exp_phase = PH_ORDER;
      end
      PH_ORDER: begin
        if (b == ORDER_SBA) begin
          exp_phase = PH_ADDR_HI;
        end else begin
          exp_phase = PH_BAD;
          exp_bad_count = 2'd0;
        end
      end
      PH_ADDR_HI: begin
        exp_high_byte = b;
        exp_phase = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        exp_field = {exp_high_byte[5:0], b[5:0]};
        exp_offset = 12'd0;
        exp_phase = PH_DATA;
      end
      PH_DATA: begin
        if (b == ORDER_SBA) begin
          exp_phase = PH_ADDR_HI;
        end else begin
          queue_result(KIND_DATA, exp_attention, exp_cursor, exp_field, exp_offset, b, 1'b0);
          if (exp_offset != OFFSET_MAX) exp_offset = exp_offset + 12'd1;
        end
      end
      default: begin
        if (exp_bad_count < BAD_NEEDED) exp_bad_count = exp_bad_count + 2'd1;
        if (exp_bad_count >= BAD_NEEDED) close_kind = KIND_BAD;
      end
    endcase

    // message end closes out and clears all state
    if (last) begin
      if (entry_phase == PH_ATTN || entry_phase == PH_CUR_HI) begin
        queue_result(KIND_SHORT, 8'd0, 12'd0, 12'd0, 12'd0, 8'd0, 1'b1);
      end else begin
        queue_result(close_kind, exp_attention, exp_cursor, exp_field, 12'd0, 8'd0, 1'b1);
      end
      exp_phase     = PH_ATTN;
      exp_attention = 8'd0;
      exp_high_byte = 8'd0;
      exp_cursor    = 12'd0;
      exp_field     = 12'd0;
      exp_offset    = 12'd0;
      exp_bad_count = 2'd0;
    end
  endfunction

  // offer one byte, wait for it to be taken, then predict
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = quiet_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      stream_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream_valid <= 1'b1;
    stream_byte  <= b;
    message_end  <= last;
    @(posedge clk);
    while (stream_stall) @(posedge clk);
    parse_byte_model(b, last);
    bytes_sent++;
  endtask

  // send the bytes held in msg_bytes as one message
  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    end
    messages_sent++;
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // any byte except the set-address order
  function automatic logic [7:0] rand_non_order();
    logic [7:0] b;
    b = rand_byte();
    if (b == ORDER_SBA) b = 8'h12;
    return b;
  endfunction

  // result side: random stall before each transaction, long hold on request
  initial begin
    int wait_cycles;
    @(negedge rst);
    forever begin
      wait_cycles = quiet_gaps ? 0 : $urandom_range(0, 10);
      if (hold_request) begin
        wait_cycles = LONG_HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (wait_cycles > 0) begin
        result_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] unexpected result: kind %0d attn %0h cur %0d fld %0d",
                    " off %0d data %0h fin %0b"},
                   $realtime, result_kind, attention_code, cursor_position, field_position,
                   byte_offset, data_value, final_result);
      end else begin
        head_result = pending_results.pop_front();
        if (result_kind !== head_result.kind || attention_code !== head_result.attention ||
            cursor_position !== head_result.cursor || field_position !== head_result.field ||
            byte_offset !== head_result.offset || data_value !== head_result.data ||
            final_result !== head_result.final_flag) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result mismatch", $realtime);
            $display("  expected: kind %0d attn %0h cur %0d fld %0d off %0d data %0h fin %0b",
                     head_result.kind, head_result.attention, head_result.cursor,
                     head_result.field, head_result.offset, head_result.data,
                     head_result.final_flag);
            $display("  actual:   kind %0d attn %0h cur %0d fld %0d off %0d data %0h fin %0b",
                     result_kind, attention_code, cursor_position, field_position,
                     byte_offset, data_value, final_result);
          end
        end
        case (head_result.kind)
          KIND_DATA:  data_results++;
          KIND_BAD:   bad_order_results++;
          KIND_SHORT: short_results++;
          default: ;
        endcase
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((stream_valid && !stream_stall) || (result_valid && !result_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] timeout: no transaction for %0d cycles, %0d results outstanding",
                 $realtime, IDLE_LIMIT, pending_results.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // messages that end on the attention byte or the first cursor byte
  task automatic test_short_messages();
    msg_bytes = '{8'hFF};
    send_message();
    msg_bytes = '{8'h00, 8'hFF};
    send_message();
  endtask

  // message ending right after the cursor address
  task automatic test_header_only();
    msg_bytes = '{8'h7D, 8'hFF, 8'hFF};
    send_message();
    msg_bytes = '{8'h00, 8'h00, 8'h00};
    send_message();
  endtask

  // data bytes at the extremes, empty field, message ending on data
  task automatic test_field_data();
    msg_bytes = '{8'h7D, 8'h40, 8'hC1, 8'h11, 8'hFF, 8'hFF, 8'h00, 8'hFF,
                  8'h11, 8'h00, 8'h05, 8'h11, 8'h3F, 8'h3F, 8'h80};
    send_message();
  endtask

  // ends on the order byte and inside the field address
  task automatic test_early_ends();
    msg_bytes = '{8'h7D, 8'h01, 8'h02, 8'h11};
    send_message();
    msg_bytes = '{8'h7D, 8'h01, 8'h02, 8'h11, 8'h05};
    send_message();
    msg_bytes = '{8'h7D, 8'h01, 8'h02, 8'h11, 8'h05, 8'h06};
    send_message();
  endtask

  // bad order byte with enough, too few and no following bytes
  task automatic test_bad_order();
    msg_bytes = '{8'hF1, 8'h01, 8'h02, 8'h00, 8'hAA, 8'hBB, 8'hCC};
    send_message();
    msg_bytes = '{8'hF1, 8'h01, 8'h02, 8'hFF, 8'hAA, 8'h11};
    send_message();
    msg_bytes = '{8'hF1, 8'h01, 8'h02, 8'h12};
    send_message();
    msg_bytes = '{8'hF1, 8'h01, 8'h02, 8'h10, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55};
    send_message();
  endtask

  // receiver holds off while the sender keeps offering bytes
  task automatic test_backpressure();
    quiet_gaps = 1'b1;
    hold_request = 1'b1;
    msg_bytes = '{8'h88, 8'h12, 8'h34, 8'h11, 8'h01, 8'h02};
    for (int i = 0; i < 60; i++) msg_bytes.push_back(rand_non_order());
    send_message();
    quiet_gaps = 1'b0;
  endtask

  // mostly well-formed messages with random content, some broken ones
  task automatic test_random_messages();
    int start_bytes;
    int sel;
    int n_fields;
    int n_data;
    int n_tail;
    logic [7:0] b;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      quiet_gaps = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 99);
      msg_bytes.delete();
      if (sel < 70) begin
        msg_bytes.push_back(rand_byte());
        msg_bytes.push_back(rand_byte());
        msg_bytes.push_back(rand_byte());
        n_fields = $urandom_range(0, 4);
        for (int f = 0; f < n_fields; f++) begin
          msg_bytes.push_back(ORDER_SBA);
          msg_bytes.push_back(rand_byte());
          msg_bytes.push_back(rand_byte());
          n_data = $urandom_range(0, 6);
          for (int d = 0; d < n_data; d++) begin
            b = ($urandom_range(0, 15) == 0) ? ORDER_SBA : rand_byte();
            msg_bytes.push_back(b);
          end
        end
      end else if (sel < 85) begin
        msg_bytes.push_back(rand_byte());
        msg_bytes.push_back(rand_byte());
        msg_bytes.push_back(rand_byte());
        msg_bytes.push_back(rand_non_order());
        n_tail = $urandom_range(0, 5);
        for (int t = 0; t < n_tail; t++) msg_bytes.push_back(rand_byte());
      end else begin
        n_tail = $urandom_range(1, 6);
        for (int t = 0; t < n_tail; t++) msg_bytes.push_back(rand_byte());
      end
      send_message();
    end
    quiet_gaps = 1'b0;
  endtask

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_messages();
    test_header_only();
    test_field_data();
    test_early_ends();
    test_bad_order();
    test_backpressure();
    test_random_messages();

    stream_valid <= 1'b0;
    message_end  <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_results.size() != 0) mismatches += pending_results.size();
    $display("Sent %0d bytes in %0d messages; checked %0d results", bytes_sent,
             messages_sent, results_checked);
    $display("  %0d data bytes, %0d bad order, %0d too short",
             data_results, bad_order_results, short_results);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
design/sifp_pkg.sv
design/sifp_step.sv
design/sifp_result_queue.sv
design/screen_inbound_field_parser_top.sv
tb/sv/screen_inbound_field_parser_top_tb.sv
